/* src/oeks_pkg.sv */
// shared types and constants for the one euro keypoint smoother
package oeks_pkg;

  // field and storage widths
  localparam int NUM_POINTS = 64;
  localparam int ADDR_W     = $clog2(NUM_POINTS);
  localparam int IDX_W      = 6;
  localparam int TS_W       = 32;
  localparam int COORD_W    = 32;
  localparam int RATE_W     = 45;
  localparam int RMAG_W     = 44;
  localparam int NUM_AXES   = 3;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CUTOFF   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_CUTOFF = 2'd2;
  localparam logic [15:0] MIN_CUTOFF_RST   = 16'd205;
  localparam logic [23:0] BETA_GAIN_RST    = 24'd26214;
  localparam logic [15:0] DERIV_CUTOFF_RST = 16'd7680;

  // arithmetic constants
  localparam logic [19:0] US_PER_S   = 20'd1000000;
  localparam logic [RMAG_W-1:0] RATE_MAX = '1;
  localparam logic [43:0] CT_MAX     = '1;
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  localparam logic [62:0] ALPHA_DEN  = 63'd16777216000000;
  localparam logic [63:0] ALPHA_NUM  = 64'd1099511627776000000;
  localparam int RATE_STEPS  = 44;
  localparam int ALPHA_STEPS = 17;

  typedef struct packed {
    logic [IDX_W-1:0]          point_index;
    logic [TS_W-1:0]           timestamp_us;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      frame_end;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          out_index;
    logic signed [COORD_W-1:0] smooth_x;
    logic signed [COORD_W-1:0] smooth_y;
    logic signed [COORD_W-1:0] smooth_z;
    logic                      out_frame_end;
  } out_item_t;

  // per point filter state
  typedef struct packed {
    logic [NUM_AXES-1:0][COORD_W-1:0] pos;
    logic [NUM_AXES-1:0][RATE_W-1:0]  rate;
  } ent_t;

  // write back from the end of the pipeline
  typedef struct packed {
    logic              we;
    logic              done;
    logic [ADDR_W-1:0] addr;
    ent_t              ent;
  } wb_t;

endpackage

/* src/oeks_rate_div.sv */
// pipelined restoring divider: saturated |d| * 1e6 / te
module oeks_rate_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [31:0]                mag_i,
  input  logic [31:0]                te_i,
  output logic [oeks_pkg::RMAG_W-1:0] rate_o
);
  import oeks_pkg::*;

  logic [51:0] n_q;
  logic [31:0] te_q;

  logic [31:0]        rem_q [RATE_STEPS];
  logic [31:0]        rem_d [RATE_STEPS];
  logic [43:0]        nb_q  [RATE_STEPS];
  logic [43:0]        nb_d  [RATE_STEPS];
  logic [RMAG_W-1:0]  q_q   [RATE_STEPS];
  logic [RMAG_W-1:0]  q_d   [RATE_STEPS];
  logic [31:0]        dv_q  [RATE_STEPS];
  logic [31:0]        dv_d  [RATE_STEPS];
  logic               sat_q [RATE_STEPS];
  logic               sat_d [RATE_STEPS];

  // one quotient bit per stage
  always_comb begin
    logic [31:0] rin;
    logic [43:0] bits;
    logic [RMAG_W-1:0] qin;
    logic [31:0] dv;
    logic        st;
    logic [32:0] trial;
    logic        ge;
    for (int j = 0; j < RATE_STEPS; j++) begin
      if (j == 0) begin
        rin  = {24'd0, n_q[51:44]};
        bits = n_q[43:0];
        qin  = '0;
        dv   = te_q;
        st   = ({24'd0, n_q[51:44]} >= te_q);
      end else begin
        rin  = rem_q[j-1];
        bits = nb_q[j-1];
        qin  = q_q[j-1];
        dv   = dv_q[j-1];
        st   = sat_q[j-1];
      end
      trial    = {rin, bits[43]};
      ge       = (trial >= {1'b0, dv});
      rem_d[j] = ge ? 32'(trial - {1'b0, dv}) : trial[31:0];
      nb_d[j]  = {bits[42:0], 1'b0};
      q_d[j]   = {qin[RMAG_W-2:0], ge};
      dv_d[j]  = dv;
      sat_d[j] = st;
    end
  end

  // scale and step registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q  <= 52'(mag_i) * 52'(US_PER_S);
      te_q <= te_i;
      for (int j = 0; j < RATE_STEPS; j++) begin
        rem_q[j] <= rem_d[j];
        nb_q[j]  <= nb_d[j];
        q_q[j]   <= q_d[j];
        dv_q[j]  <= dv_d[j];
        sat_q[j] <= sat_d[j];
      end
    end
  end

  assign rate_o = sat_q[RATE_STEPS-1] ? RATE_MAX : q_q[RATE_STEPS-1];

endmodule

/* src/oeks_alpha.sv */
// pipelined smoothing factor: alpha = r / (r + 1), r = 2*pi*f*te
module oeks_alpha (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] freq_i,
  input  logic [31:0] te_i,
  output logic [15:0] alpha_o
);
  import oeks_pkg::*;

  logic [47:0] p_q;
  logic [62:0] s_q;
  logic [43:0] ct;
  logic [63:0] x;

  logic [62:0] rem_q [ALPHA_STEPS];
  logic [62:0] rem_d [ALPHA_STEPS];
  logic [16:0] nb_q  [ALPHA_STEPS];
  logic [16:0] nb_d  [ALPHA_STEPS];
  logic [16:0] q_q   [ALPHA_STEPS];
  logic [16:0] q_d   [ALPHA_STEPS];
  logic [62:0] dv_q  [ALPHA_STEPS];
  logic [62:0] dv_d  [ALPHA_STEPS];

  // saturated cutoff-time product and rounded-up numerator
  assign ct = (|p_q[47:44]) ? CT_MAX : p_q[43:0];
  assign x  = ALPHA_NUM + {1'b0, s_q} - 64'd1;

  // one quotient bit per stage
  always_comb begin
    logic [62:0] rin;
    logic [16:0] bits;
    logic [16:0] qin;
    logic [62:0] dv;
    logic [63:0] trial;
    logic        ge;
    for (int j = 0; j < ALPHA_STEPS; j++) begin
      if (j == 0) begin
        rin  = {16'd0, x[63:17]};
        bits = x[16:0];
        qin  = '0;
        dv   = s_q;
      end else begin
        rin  = rem_q[j-1];
        bits = nb_q[j-1];
        qin  = q_q[j-1];
        dv   = dv_q[j-1];
      end
      trial    = {rin, bits[16]};
      ge       = (trial >= {1'b0, dv});
      rem_d[j] = ge ? 63'(trial - {1'b0, dv}) : trial[62:0];
      nb_d[j]  = {bits[15:0], 1'b0};
      q_d[j]   = {qin[15:0], ge};
      dv_d[j]  = dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= 48'(freq_i) * 48'(te_i);
      s_q <= 63'(63'(ct) * 63'(TWO_PI_Q16)) + ALPHA_DEN;
      for (int j = 0; j < ALPHA_STEPS; j++) begin
        rem_q[j] <= rem_d[j];
        nb_q[j]  <= nb_d[j];
        q_q[j]   <= q_d[j];
        dv_q[j]  <= dv_d[j];
      end
    end
  end

  assign alpha_o = 16'(17'h10000 - q_q[ALPHA_STEPS-1]);

endmodule

/* src/oeks_state.sv */
// per point filter memory with seen and busy flags
module oeks_state (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [oeks_pkg::ADDR_W-1:0]   rd_idx_i,
  input  logic                          acc_i,
  input  oeks_pkg::wb_t                 wb_i,
  output oeks_pkg::ent_t                rd_ent_o,
  output logic                          seen_o,
  output logic                          busy_o
);
  import oeks_pkg::*;

  ent_t mem_q [NUM_POINTS];
  ent_t rd_q;
  logic [NUM_POINTS-1:0] seen_q;
  logic [NUM_POINTS-1:0] busy_q;
  logic [NUM_POINTS-1:0] busy_d;

  // state memory, registered read
  always_ff @(posedge clk_i) begin
    if (wb_i.we) begin
      mem_q[wb_i.addr] <= wb_i.ent;
    end
    if (adv_i) begin
      rd_q <= mem_q[rd_idx_i];
    end
  end

  // a point is busy from accept until its write back
  always_comb begin
    busy_d = busy_q;
    if (wb_i.done) begin
      busy_d[wb_i.addr] = 1'b0;
    end
    if (acc_i) begin
      busy_d[rd_idx_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      busy_q <= '0;
    end else begin
      busy_q <= busy_d;
      if (acc_i) begin
        seen_q[rd_idx_i] <= 1'b1;
      end
    end
  end

  assign rd_ent_o = rd_q;
  assign seen_o   = seen_q[rd_idx_i];
  assign busy_o   = busy_q[rd_idx_i];

endmodule

/* src/one_euro_keypoint_smoother_3d_top.sv */
// one euro keypoint smoother: top level pipeline
//
// Input items (index, timestamp, x/y/z, frame end) enter on in_valid_i and are
// taken on a clock edge where in_stall_o is low. Each item gives exactly one
// result item on out_valid_o / out_item_o, held until out_stall_i is low.
// One item is taken per cycle while in_stall_o is low. An item whose point index
// matches an item still in flight waits (in_stall_o high) until that item has
// written its state back, so items of one point do not overlap in the pipeline.
// The depth is set by the rate divider followed by the position smoothing factor
// unit in series, with the derivative smoothing factor unit beside the divider.
// When out_stall_i holds a result, the whole pipeline holds and input stalls.
// Configuration (min cutoff, beta gain, derivative cutoff) is written on cfg_we_i with
// cfg_index_i / cfg_data_i; the user must write it only while no item is in flight, as the block does not enforce this.
// Reset clears the seen and busy flags, the frame time and all valid bits;
// the filter memory needs no clearing pass.
module one_euro_keypoint_smoother_3d_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  oeks_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output oeks_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [oeks_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [oeks_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import oeks_pkg::*;

  localparam int NS            = 73;
  localparam int ST_RATE_IN    = 3;
  localparam int ST_RATE_OUT   = ST_RATE_IN + RATE_STEPS + 1;
  localparam int ST_DALPHA_IN  = ST_RATE_OUT + 1 - (ALPHA_STEPS + 2);
  localparam int ST_DALPHA_OUT = ST_DALPHA_IN + ALPHA_STEPS + 2;
  localparam int ST_PALPHA_IN  = ST_DALPHA_OUT + 4;
  localparam int ST_PALPHA_OUT = ST_PALPHA_IN + ALPHA_STEPS + 2;

  typedef struct packed {
    logic [IDX_W-1:0]                 idx;
    logic                             fend;
    logic                             inr;
    logic                             first;
    logic                             upd;
    logic [TS_W-1:0]                  te;
    logic [NUM_AXES-1:0][COORD_W-1:0] cur;
    logic [NUM_AXES-1:0][COORD_W-1:0] prev;
    logic [NUM_AXES-1:0][RATE_W-1:0]  prate;
    logic [NUM_AXES-1:0][COORD_W:0]   d;
    logic [NUM_AXES-1:0][COORD_W-1:0] m;
    logic [NUM_AXES-1:0][RATE_W:0]    dd;
    logic [NUM_AXES-1:0][61:0]        dprod;
    logic [NUM_AXES-1:0][RATE_W-1:0]  rh;
    logic [NUM_AXES-1:0][RMAG_W-1:0]  rm;
    logic [NUM_AXES-1:0][67:0]        bprod;
    logic [NUM_AXES-1:0][48:0]        pprod;
  } side_t;

  logic [15:0] min_cutoff_q;
  logic [23:0] beta_gain_q;
  logic [15:0] deriv_cutoff_q;
  logic [TS_W-1:0] prev_time_q;
  logic            time_valid_q;

  side_t side_q [1:NS];
  side_t side_d [1:NS];
  logic [NS:1] vld_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic adv, accept, in_range, seen, busy;
  logic [TS_W-1:0] te_in;
  ent_t rd_ent;
  wb_t  wb;

  logic [RMAG_W-1:0] rate_q_mag [NUM_AXES];
  logic [15:0]       alpha_d;
  logic [15:0]       alpha_p [NUM_AXES];
  logic [15:0]       cut     [NUM_AXES];
  logic [NUM_AXES-1:0][COORD_W-1:0] pos_new;
  logic [NUM_AXES-1:0][COORD_W-1:0] res;

  // handshake
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_range   = int'(in_item_i.point_index) < NUM_POINTS;
  assign in_stall_o = !adv || (in_range && busy);
  assign accept     = in_valid_i && !in_stall_o;
  assign te_in      = time_valid_q ? (in_item_i.timestamp_us - prev_time_q) : '0;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cutoff_q   <= MIN_CUTOFF_RST;
      beta_gain_q    <= BETA_GAIN_RST;
      deriv_cutoff_q <= DERIV_CUTOFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_CUTOFF:   min_cutoff_q   <= cfg_data_i[15:0];
        CFG_BETA_GAIN:    beta_gain_q    <= cfg_data_i;
        CFG_DERIV_CUTOFF: deriv_cutoff_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // frame time commits on accept of a frame end item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q  <= '0;
      time_valid_q <= 1'b0;
    end else if (accept && in_item_i.frame_end) begin
      prev_time_q  <= in_item_i.timestamp_us;
      time_valid_q <= 1'b1;
    end
  end

  oeks_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .rd_idx_i (in_item_i.point_index[ADDR_W-1:0]),
    .acc_i    (accept && in_range),
    .wb_i     (wb),
    .rd_ent_o (rd_ent),
    .seen_o   (seen),
    .busy_o   (busy)
  );

  // per axis rate dividers and position smoothing factors
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    oeks_rate_div u_rate (
      .clk_i  (clk_i),
      .en_i   (adv),
      .mag_i  (side_q[ST_RATE_IN].m[a]),
      .te_i   (side_q[ST_RATE_IN].te),
      .rate_o (rate_q_mag[a])
    );
    oeks_alpha u_palpha (
      .clk_i   (clk_i),
      .en_i    (adv),
      .freq_i  (cut[a]),
      .te_i    (side_q[ST_PALPHA_IN].te),
      .alpha_o (alpha_p[a])
    );
  end

  oeks_alpha u_dalpha (
    .clk_i   (clk_i),
    .en_i    (adv),
    .freq_i  (deriv_cutoff_q),
    .te_i    (side_q[ST_DALPHA_IN].te),
    .alpha_o (alpha_d)
  );

  // cutoff from the smoothed rate, saturated
  always_comb begin
    logic [44:0] csum;
    for (int a = 0; a < NUM_AXES; a++) begin
      csum   = 45'(min_cutoff_q) + 45'(side_q[ST_PALPHA_IN].bprod[a][67:24]);
      cut[a] = (|csum[44:16]) ? 16'hFFFF : csum[15:0];
    end
  end

  // stage data path
  always_comb begin
    logic [RMAG_W-1:0]   q;
    logic [RATE_W-1:0]   dx;
    logic signed [62:0]  dp;
    logic signed [49:0]  pp;
    logic [RATE_W:0]     rs;
    side_d[1]       = '0;
    side_d[1].idx   = in_item_i.point_index;
    side_d[1].fend  = in_item_i.frame_end;
    side_d[1].inr   = in_range;
    side_d[1].first = in_range && !seen;
    side_d[1].upd   = in_range && seen && (te_in != '0);
    side_d[1].te    = te_in;
    side_d[1].cur[0] = in_item_i.pos_x;
    side_d[1].cur[1] = in_item_i.pos_y;
    side_d[1].cur[2] = in_item_i.pos_z;
    for (int k = 2; k <= NS; k++) begin
      side_d[k] = side_q[k-1];
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      // stored state and position step
      side_d[2].prev[a]  = rd_ent.pos[a];
      side_d[2].prate[a] = rd_ent.rate[a];
      side_d[2].d[a]     = {side_q[1].cur[a][COORD_W-1], side_q[1].cur[a]}
                         - {rd_ent.pos[a][COORD_W-1], rd_ent.pos[a]};
      // step magnitude
      side_d[3].m[a] = side_q[2].d[a][COORD_W] ? COORD_W'(33'd0 - side_q[2].d[a])
                                               : side_q[2].d[a][COORD_W-1:0];
      // signed raw rate minus previous rate
      q  = rate_q_mag[a];
      dx = side_q[ST_RATE_OUT].d[a][COORD_W] ? RATE_W'(45'd0 - {1'b0, q}) : {1'b0, q};
      side_d[ST_RATE_OUT+1].dd[a] = {dx[RATE_W-1], dx}
        - {side_q[ST_RATE_OUT].prate[a][RATE_W-1], side_q[ST_RATE_OUT].prate[a]};
      // derivative smoothing product
      dp = $signed(side_q[ST_DALPHA_OUT].dd[a]) * $signed({1'b0, alpha_d});
      side_d[ST_DALPHA_OUT+1].dprod[a] = dp[61:0];
      // smoothed rate
      rs = {side_q[ST_DALPHA_OUT+1].prate[a][RATE_W-1], side_q[ST_DALPHA_OUT+1].prate[a]}
         + side_q[ST_DALPHA_OUT+1].dprod[a][61:16];
      side_d[ST_DALPHA_OUT+2].rh[a] = rs[RATE_W-1:0];
      // rate magnitude
      side_d[ST_DALPHA_OUT+3].rm[a] = side_q[ST_DALPHA_OUT+2].rh[a][RATE_W-1]
        ? RMAG_W'(45'd0 - side_q[ST_DALPHA_OUT+2].rh[a])
        : side_q[ST_DALPHA_OUT+2].rh[a][RMAG_W-1:0];
      // beta times rate magnitude
      side_d[ST_PALPHA_IN].bprod[a] = 68'(beta_gain_q) * 68'(side_q[ST_PALPHA_IN-1].rm[a]);
      // position smoothing product
      pp = $signed(side_q[ST_PALPHA_OUT].d[a]) * $signed({1'b0, alpha_p[a]});
      side_d[ST_PALPHA_OUT+1].pprod[a] = pp[48:0];
    end
  end

  // final position and result select
  always_comb begin
    logic [COORD_W:0] sum;
    for (int a = 0; a < NUM_AXES; a++) begin
      sum = {side_q[NS].prev[a][COORD_W-1], side_q[NS].prev[a]}
          + side_q[NS].pprod[a][48:16];
      pos_new[a] = sum[COORD_W-1:0];
      if (side_q[NS].upd) begin
        res[a] = pos_new[a];
      end else if (side_q[NS].inr && !side_q[NS].first) begin
        res[a] = side_q[NS].prev[a];
      end else begin
        res[a] = side_q[NS].cur[a];
      end
    end
  end

  // write back of the point state
  always_comb begin
    wb      = '0;
    wb.done = adv && vld_q[NS] && side_q[NS].inr;
    wb.we   = wb.done && (side_q[NS].first || side_q[NS].upd);
    wb.addr = side_q[NS].idx[ADDR_W-1:0];
    for (int a = 0; a < NUM_AXES; a++) begin
      wb.ent.pos[a]  = side_q[NS].first ? side_q[NS].cur[a] : pos_new[a];
      wb.ent.rate[a] = side_q[NS].first ? '0 : side_q[NS].rh[a];
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[NS-1:1], accept};
      out_valid_q <= vld_q[NS];
    end
  end

  // pipeline payload and output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 1; k <= NS; k++) begin
        side_q[k] <= side_d[k];
      end
      out_q.out_index     <= side_q[NS].idx;
      out_q.smooth_x      <= res[0];
      out_q.smooth_y      <= res[1];
      out_q.smooth_z      <= res[2];
      out_q.out_frame_end <= side_q[NS].fend;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* dv/one_euro_keypoint_smoother_3d_checker.sv */
// checker for the one euro keypoint smoother: predicts and compares result items
module one_euro_keypoint_smoother_3d_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  oeks_pkg::in_item_t              in_item_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  oeks_pkg::out_item_t             out_item_i,
  input  logic                            cfg_we_i,
  input  logic [oeks_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [oeks_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import oeks_pkg::*;

  localparam longint unsigned RATE_LIMIT = 64'd17592186044415;
  localparam longint unsigned CT_LIMIT   = 64'd17592186044415;
  localparam longint unsigned DEN_Q      = 64'd16777216000000;
  localparam longint unsigned PI2_Q16    = 64'd411775;
  localparam longint unsigned MICROS     = 64'd1000000;

  // filter state kept by the predictor
  longint      pos_mem  [NUM_POINTS][NUM_AXES];
  longint      rate_mem [NUM_POINTS][NUM_AXES];
  bit          seen_mem [NUM_POINTS];
  logic [31:0] frame_time;
  bit          frame_time_ok;
  longint unsigned min_cut, beta, d_cut;

  out_item_t   smoothed_q[$];

  function automatic longint unsigned magnitude(longint d);
    return (d < 0) ? -d : d;
  endfunction

  // floor(d * a / 65536)
  function automatic longint scale_by_alpha(longint d, longint unsigned a);
    longint unsigned m, hi, lo;
    m  = magnitude(d);
    hi = m >> 16;
    lo = m & 64'hFFFF;
    if (d < 0) return -longint'(a * hi + ((a * lo + 64'd65535) >> 16));
    return longint'(a * hi + ((a * lo) >> 16));
  endfunction

  // alpha = r/(r+1) in q0.16
  function automatic longint unsigned alpha_of(longint unsigned f, longint unsigned te);
    longint unsigned ct, s;
    ct = f * te;
    if (ct > CT_LIMIT) ct = CT_LIMIT;
    s = ct * PI2_Q16 + DEN_Q;
    return 64'd65536 - (((DEN_Q << 16) + s - 1) / s);
  endfunction

  // raw rate of change per second, saturated
  function automatic longint rate_per_s(longint d, longint unsigned te);
    longint unsigned m, q, r, v;
    m = magnitude(d);
    q = m / te;
    r = m % te;
    if (q > RATE_LIMIT / MICROS) begin
      v = RATE_LIMIT;
    end else begin
      v = q * MICROS + (r * MICROS) / te;
      if (v > RATE_LIMIT) v = RATE_LIMIT;
    end
    return (d < 0) ? -longint'(v) : longint'(v);
  endfunction

  function automatic out_item_t smooth_point(in_item_t it);
    out_item_t       res;
    longint          cur [NUM_AXES];
    longint          outv[NUM_AXES];
    longint          prev, prate, dx, rh;
    longint unsigned te, ad, rm, cut;
    int              idx;
    idx = it.point_index;
    cur[0] = longint'(it.pos_x);
    cur[1] = longint'(it.pos_y);
    cur[2] = longint'(it.pos_z);
    outv = cur;
    if (!seen_mem[idx]) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        pos_mem[idx][k]  = cur[k];
        rate_mem[idx][k] = 0;
      end
      seen_mem[idx] = 1;
    end else begin
      te = frame_time_ok ? longint'({32'd0, it.timestamp_us - frame_time}) : 0;
      if (te == 0) begin
        for (int k = 0; k < NUM_AXES; k++) outv[k] = pos_mem[idx][k];
      end else begin
        ad = alpha_of(d_cut, te);
        for (int k = 0; k < NUM_AXES; k++) begin
          prev  = pos_mem[idx][k];
          prate = rate_mem[idx][k];
          dx    = rate_per_s(cur[k] - prev, te);
          rh    = prate + scale_by_alpha(dx - prate, ad);
          rm    = magnitude(rh);
          if (beta != 0 && rm > 64'hFFFF_FFFF_FFFF_FFFF / beta) begin
            cut = 65535;
          end else begin
            cut = min_cut + ((beta * rm) >> 24);
            if (cut > 65535) cut = 65535;
          end
          outv[k] = prev + scale_by_alpha(cur[k] - prev, alpha_of(cut, te));
          pos_mem[idx][k]  = outv[k];
          rate_mem[idx][k] = rh;
        end
      end
    end
    if (it.frame_end) begin
      frame_time    = it.timestamp_us;
      frame_time_ok = 1;
    end
    res.out_index     = it.point_index;
    res.smooth_x      = outv[0][31:0];
    res.smooth_y      = outv[1][31:0];
    res.smooth_z      = outv[2][31:0];
    res.out_frame_end = it.frame_end;
    return res;
  endfunction

  // watch config writes, accepted inputs and accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t pred;
    if (!rst_ni) begin
      foreach (seen_mem[i]) seen_mem[i] = 0;
      frame_time    = '0;
      frame_time_ok = 0;
      min_cut       = MIN_CUTOFF_RST;
      beta          = BETA_GAIN_RST;
      d_cut         = DERIV_CUTOFF_RST;
      fail_count_o  = 0;
      smoothed_q.delete();
      pending_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MIN_CUTOFF:   min_cut = cfg_data_i[15:0];
          CFG_BETA_GAIN:    beta    = cfg_data_i;
          CFG_DERIV_CUTOFF: d_cut   = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (smoothed_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %p", $time, out_item_i);
          fail_count_o++;
        end else begin
          want = smoothed_q.pop_front();
          if (out_item_i !== want) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, out_item_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pred = smooth_point(in_item_i);
        smoothed_q = {smoothed_q, pred};
      end
      pending_o = smoothed_q.size();
    end
  end

endmodule

/* dv/one_euro_keypoint_smoother_3d_top_test.sv */
// testbench top for the one euro keypoint smoother: stimulus and verdict
module one_euro_keypoint_smoother_3d_top_test;
  import oeks_pkg::*;

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      in_valid_i = 0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 0;
  out_item_t out_item_o;
  logic      cfg_we_i = 0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int        fail_count, pending;
  int        idle_pct = 0, stall_pct = 0;
  logic [31:0] frame_ts = 0;
  int        walk [NUM_POINTS][NUM_AXES];

  one_euro_keypoint_smoother_3d_top uut (.*);

  one_euro_keypoint_smoother_3d_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_item_i(out_item_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // present one item and hold it until taken; valid drops only when idling
  task automatic send_point(input int idx, input logic [31:0] ts,
                            input int x, input int y, input int z, input bit fend);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    in_item_i  <= '{point_index: IDX_W'(idx), timestamp_us: ts, pos_x: x, pos_y: y,
                    pos_z: z, frame_end: fend};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // drain, let the pipeline empty, then write the three registers
  task automatic set_filter(input logic [15:0] mc, input logic [23:0] bg,
                            input logic [15:0] dc);
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_index_i <= CFG_MIN_CUTOFF;   cfg_data_i <= {8'd0, mc}; @(negedge clk_i);
    cfg_index_i <= CFG_BETA_GAIN;    cfg_data_i <= bg;         @(negedge clk_i);
    cfg_index_i <= CFG_DERIV_CUTOFF; cfg_data_i <= {8'd0, dc}; @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  // one frame of a few points moving a little, with occasional jumps
  task automatic send_frame(output int sent);
    int n, idx, c[NUM_AXES];
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5)       frame_ts = frame_ts;
    else if (pick < 10) frame_ts = frame_ts + $urandom();
    else if (pick < 40) frame_ts = frame_ts + $urandom_range(1, 200);
    else                frame_ts = frame_ts + $urandom_range(8000, 40000);
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      idx = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7);
      for (int k = 0; k < NUM_AXES; k++) begin
        if ($urandom_range(9) == 0) walk[idx][k] = $urandom();
        else walk[idx][k] += $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        c[k] = walk[idx][k];
      end
      send_point(idx, frame_ts, c[0], c[1], c[2], (i == n - 1) || ($urandom_range(9) == 0));
    end
    sent = n;
  endtask

  task automatic random_phase(input int items);
    int start, sent;
    start = 0;
    while (start < items) begin
      if ($urandom_range(19) == 0) begin
        send_point($urandom_range(63), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom_range(1));
        start += 1;
      end else begin
        send_frame(sent);
        start += sent;
      end
    end
  endtask

  // stimulus
  initial begin
    foreach (walk[i, k]) walk[i][k] = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // first samples, zero elapsed time before and after a frame commit
    send_point(0, 1000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
    send_point(63, 1000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    send_point(0, 1000, 0, 0, 0, 0);
    send_point(1, 1000, 1, -1, 0, 1);
    send_point(0, 1000, 5, 6, 7, 0);
    // normal steps, saturating rates, tiny and wrapped elapsed time
    send_point(0, 2000, 32'h80000000, 0, -1, 0);
    send_point(63, 2000, 32'h7fffffff, 32'h7fffffff, 0, 1);
    send_point(0, 2001, 100, -100, 65536, 1);
    send_point(1, 2000, 32'h12345678, 32'hedcba987, 32'h55555555, 1);
    send_point(1, 32'hffffffff, 32'haaaaaaaa, 32'h55555555, 32'hffffffff, 1);
    send_point(63, 32'hffffffff, 0, 0, 0, 1);
    send_point(63, 50, 3, 3, 3, 1);
    frame_ts = 50;

    set_filter('0, '0, '0);
    idle_pct = 0;  stall_pct = 0;
    random_phase(175);
    set_filter(16'hffff, 24'hffffff, 16'hffff);
    idle_pct = 59; stall_pct = 0;
    random_phase(175);
    set_filter(16'($urandom()), 24'($urandom()), 16'($urandom()));
    idle_pct = 0;  stall_pct = 59;
    random_phase(175);
    set_filter(MIN_CUTOFF_RST, BETA_GAIN_RST, DERIV_CUTOFF_RST);
    idle_pct = 30; stall_pct = 30;
    random_phase(175);

    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
